@@ src/ubx_pkg.sv @@
// ----------------------------------------------------------------------------
// ubx_pkg: shared types and constants of the UBX frame parser
// Event codes, register indexes and the field widths used by the channels.
// ----------------------------------------------------------------------------
package ubx_pkg;

   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 16;
   localparam int EVENT_W  = 3;
   localparam int CSR_IDX_W = 2;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [LENGTH_W-1:0]  length_type;
   typedef logic [EVENT_W-1:0]   event_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Result event codes.
   localparam event_type EV_IDLE    = 3'd0;
   localparam event_type EV_PAYLOAD = 3'd1;
   localparam event_type EV_GOOD    = 3'd2;
   localparam event_type EV_BADSYNC = 3'd3;
   localparam event_type EV_TOOLONG = 3'd4;
   localparam event_type EV_OVERRUN = 3'd5;
   localparam event_type EV_BADCHKA = 3'd6;
   localparam event_type EV_BADCHKB = 3'd7;

   // Configuration register indexes.
   localparam csr_idx_type CSR_SYNC_FIRST   = 2'd0;
   localparam csr_idx_type CSR_SYNC_SECOND  = 2'd1;
   localparam csr_idx_type CSR_LENGTH_LIMIT = 2'd2;

   // Reset values of the configuration registers.
   localparam byte_type   SYNC_FIRST_RST   = 8'hB5;
   localparam byte_type   SYNC_SECOND_RST  = 8'h62;
   localparam length_type LENGTH_LIMIT_RST = 16'd256;

endpackage

@@ src/ubx_if.sv @@
// ----------------------------------------------------------------------------
// ubx_if: channel interfaces of the UBX frame parser
// Receive byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ubx_req_if;
   logic               valid;
   logic               ready;
   ubx_pkg::byte_type  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_rsp_if;
   logic                valid;
   logic                ready;
   ubx_pkg::event_type  event_res;
   ubx_pkg::byte_type   payload_byte;
   ubx_pkg::byte_type   payload_offset;
   ubx_pkg::byte_type   frame_class;
   ubx_pkg::byte_type   frame_id;
   ubx_pkg::length_type frame_length;

   modport source (output valid, output event_res, output payload_byte,
                   output payload_offset, output frame_class, output frame_id,
                   output frame_length, input ready);
   modport sink   (input valid, input event_res, input payload_byte,
                   input payload_offset, input frame_class, input frame_id,
                   input frame_length, output ready);
endinterface

interface ubx_csr_if;
   logic                 valid;
   logic                 ready;
   ubx_pkg::csr_idx_type index;
   ubx_pkg::length_type  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ src/ubx_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ubx_frame_parser: UBX frame hunter with Fletcher-8 check, one result per byte
// A result is registered and valid in the cycle after its byte transaction is taken.
// Throughput: one byte per cycle while the result sink keeps up; the frame state update is one short step.
// Reset (synchronous): hunt for first sync, registers back to their defaults.
// ----------------------------------------------------------------------------
module ubx_frame_parser #(
   parameter int PAYLOAD_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   ubx_req_if.sink      req_if,
   ubx_rsp_if.source    rsp_if,
   ubx_csr_if.sink      csr_if
);
   import ubx_pkg::*;

   // The payload counter only needs to reach PAYLOAD_BYTES; a byte arriving
   // once it is there is an overrun.
   localparam int CNT_W = (PAYLOAD_BYTES < 2) ? 1 : $clog2(PAYLOAD_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PAYLOAD_BYTES);

   // Frame phase codes.
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CHK_A   = 4'd7;
   localparam logic [3:0] PH_CHK_B   = 4'd8;

   // Configuration registers.
   byte_type   sync_first_ff,  sync_first_in;
   byte_type   sync_second_ff, sync_second_in;
   length_type length_limit_ff, length_limit_in;

   // Frame state.
   logic [3:0]       phase_ff, phase_in;
   byte_type         class_ff, class_in;
   byte_type         id_ff, id_in;
   length_type       length_ff, length_in;
   byte_type         sum_a_ff, sum_a_in;
   byte_type         sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   event_type  event_ff, event_in;
   byte_type   pbyte_ff, pbyte_in;
   byte_type   poff_ff, poff_in;

   logic       req_take;
   byte_type   rx;
   byte_type   sum_a_add;
   byte_type   sum_b_add;
   length_type len_full;
   length_type count_next;
   length_type count_wide;

   // A new byte is taken whenever the result register is empty or is being
   // drained in the same cycle, so back-to-back transactions run at full rate.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rx = req_if.rx_byte;

   // One Fletcher-8 step on the incoming byte.
   assign sum_a_add = sum_a_ff + rx;
   assign sum_b_add = sum_b_ff + sum_a_add;

   // Declared length once the high byte arrives.
   assign len_full = {rx, length_ff[7:0]};

   assign count_wide = LENGTH_W'(count_ff);
   assign count_next = count_wide + 16'd1;

   always_comb begin
      sync_first_in   = sync_first_ff;
      sync_second_in  = sync_second_ff;
      length_limit_in = length_limit_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_SYNC_FIRST:   sync_first_in   = csr_if.wdata[BYTE_W-1:0];
            CSR_SYNC_SECOND:  sync_second_in  = csr_if.wdata[BYTE_W-1:0];
            CSR_LENGTH_LIMIT: length_limit_in = csr_if.wdata;
            default:          ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      count_in  = count_ff;
      event_in  = EV_IDLE;
      pbyte_in  = '0;
      poff_in   = '0;

      case (phase_ff)
         PH_SYNC1: begin
            if (rx == sync_first_ff) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            // A wrong second sync byte is reported and not re-tested as a
            // first sync byte.
            if (rx == sync_second_ff) begin
               phase_in = PH_CLASS;
               sum_a_in = '0;
               sum_b_in = '0;
            end else begin
               phase_in = PH_SYNC1;
               event_in = EV_BADSYNC;
            end
         end
         PH_CLASS: begin
            class_in = rx;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = rx;
            sum_a_in = sum_a_add;
            sum_b_in = sum_b_add;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, rx};
            sum_a_in  = sum_a_add;
            sum_b_in  = sum_b_add;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            // The declared length is kept even when the frame is dropped,
            // so the drop result shows it.
            length_in = len_full;
            if (len_full < length_limit_ff) begin
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               count_in = '0;
               // An empty payload goes straight to the check bytes.
               phase_in = (len_full == '0) ? PH_CHK_A : PH_PAYLOAD;
            end else begin
               phase_in = PH_SYNC1;
               event_in = EV_TOOLONG;
            end
         end
         PH_PAYLOAD: begin
            if (count_ff < CNT_MAX) begin
               sum_a_in = sum_a_add;
               sum_b_in = sum_b_add;
               event_in = EV_PAYLOAD;
               pbyte_in = rx;
               poff_in  = count_wide[BYTE_W-1:0];
               count_in = count_next[CNT_W-1:0];
               if (count_next == length_ff) begin
                  phase_in = PH_CHK_A;
               end
            end else begin
               phase_in = PH_SYNC1;
               event_in = EV_OVERRUN;
            end
         end
         PH_CHK_A: begin
            if (rx == sum_a_ff) begin
               phase_in = PH_CHK_B;
            end else begin
               phase_in = PH_SYNC1;
               event_in = EV_BADCHKA;
            end
         end
         PH_CHK_B: begin
            phase_in = PH_SYNC1;
            event_in = (rx == sum_b_ff) ? EV_GOOD : EV_BADCHKB;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   // The result register holds until the sink takes it; a fresh byte loads it
   // when it is empty or in the same cycle as the old result leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RST;
         sync_second_ff  <= SYNC_SECOND_RST;
         length_limit_ff <= LENGTH_LIMIT_RST;
         phase_ff        <= PH_SYNC1;
         class_ff        <= '0;
         id_ff           <= '0;
         length_ff       <= '0;
         sum_a_ff        <= '0;
         sum_b_ff        <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sync_first_ff   <= sync_first_in;
         sync_second_ff  <= sync_second_in;
         length_limit_ff <= length_limit_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (req_take) begin
            phase_ff  <= phase_in;
            class_ff  <= class_in;
            id_ff     <= id_in;
            length_ff <= length_in;
            sum_a_ff  <= sum_a_in;
            sum_b_ff  <= sum_b_in;
            count_ff  <= count_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_take) begin
         event_ff <= event_in;
         pbyte_ff <= pbyte_in;
         poff_ff  <= poff_in;
      end
   end

   // Frame fields show the state after the byte that produced the result,
   // which is exactly what the state registers hold while the result waits.
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.event_res      = event_ff;
   assign rsp_if.payload_byte   = pbyte_ff;
   assign rsp_if.payload_offset = poff_ff;
   assign rsp_if.frame_class    = class_ff;
   assign rsp_if.frame_id       = id_ff;
   assign rsp_if.frame_length   = length_ff;

endmodule
